>>> rtl/core/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared constants and types for the quadratic root solver pipeline.
// ----------------------------------------------------------------------------
package qrs_pkg;

    localparam int COEF_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int ROOT_WIDTH     = 34;

    typedef enum logic [1:0] {
        ST_REAL    = 2'd0,
        ST_NO_REAL = 2'd1,
        ST_A_ZERO  = 2'd2
    } t_status;

endpackage

>>> rtl/core/qrs_disc.sv
// ----------------------------------------------------------------------------
// qrs_disc
// Three-stage front end: coefficient magnitudes, products, discriminant.
// ----------------------------------------------------------------------------
module qrs_disc import qrs_pkg::*; #(
    parameter int CW = COEF_WIDTH_DEF,
    localparam int DW = 2 * CW + 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [CW-1:0]        i_a,
    input  logic [CW-1:0]        i_b,
    input  logic [CW-1:0]        i_c,
    output logic                 o_valid,
    output logic [DW-1:0]        o_disc,
    output logic                 o_b_neg,
    output logic [CW-1:0]        o_b_mag,
    output logic                 o_a_neg,
    output logic [CW-1:0]        o_a_mag,
    output t_status              o_status
);

    logic          r1_valid, r2_valid, r3_valid;
    logic          r1_a_neg, r1_b_neg, r1_c_neg;
    logic [CW-1:0] r1_a_mag, r1_b_mag, r1_c_mag;
    logic              r2_a_neg, r2_b_neg, r2_same_sign, r2_a_zero;
    logic [CW-1:0]     r2_a_mag, r2_b_mag;
    logic [2*CW-1:0]   r2_b2, r2_ac;
    logic [DW-1:0]     r3_disc;
    logic              r3_a_neg, r3_b_neg;
    logic [CW-1:0]     r3_a_mag, r3_b_mag;
    t_status           r3_status;

    logic [DW-1:0] n_b2x, n_ac4, n_disc;
    logic          n_neg_disc;
    t_status       n_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_a_neg <= i_a[CW-1];
            r1_b_neg <= i_b[CW-1];
            r1_c_neg <= i_c[CW-1];
            r1_a_mag <= i_a[CW-1] ? (~i_a + 1'b1) : i_a;
            r1_b_mag <= i_b[CW-1] ? (~i_b + 1'b1) : i_b;
            r1_c_mag <= i_c[CW-1] ? (~i_c + 1'b1) : i_c;

            r2_b2        <= r1_b_mag * r1_b_mag;
            r2_ac        <= r1_a_mag * r1_c_mag;
            r2_a_neg     <= r1_a_neg;
            r2_b_neg     <= r1_b_neg;
            r2_a_mag     <= r1_a_mag;
            r2_b_mag     <= r1_b_mag;
            r2_same_sign <= (r1_a_neg == r1_c_neg) && (r1_c_mag != '0);
            r2_a_zero    <= (r1_a_mag == '0);

            r3_disc   <= n_disc;
            r3_status <= n_status;
            r3_a_neg  <= r2_a_neg;
            r3_b_neg  <= r2_b_neg;
            r3_a_mag  <= r2_a_mag;
            r3_b_mag  <= r2_b_mag;
        end
    end

    // The product magnitude never exceeds 2^(2CW-2), so its top bit is free.
    always_comb begin
        n_b2x      = {1'b0, r2_b2};
        n_ac4      = {r2_ac[2*CW-2:0], 2'b00};
        n_neg_disc = r2_same_sign && (n_ac4 > n_b2x);
        n_disc     = r2_same_sign ? (n_b2x - n_ac4) : (n_b2x + n_ac4);
        if (r2_a_zero) begin
            n_status = ST_A_ZERO;
        end else if (n_neg_disc) begin
            n_status = ST_NO_REAL;
        end else begin
            n_status = ST_REAL;
        end
    end

    assign o_valid  = r3_valid;
    assign o_disc   = r3_disc;
    assign o_b_neg  = r3_b_neg;
    assign o_b_mag  = r3_b_mag;
    assign o_a_neg  = r3_a_neg;
    assign o_a_mag  = r3_a_mag;
    assign o_status = r3_status;

endmodule

>>> rtl/core/qrs_sqrt.sv
// ----------------------------------------------------------------------------
// qrs_sqrt
// Pipelined restoring square root, one root bit per stage.
// ----------------------------------------------------------------------------
module qrs_sqrt #(
    parameter int DW = 33,
    parameter int FB = 16,
    parameter int SB = 1,
    localparam int SW = (DW + 1) / 2 + FB,
    localparam int RW = 2 * SW
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [DW-1:0] i_rad,
    input  logic [SB-1:0] i_side,
    output logic          o_valid,
    output logic [SW-1:0] o_root,
    output logic [SB-1:0] o_side
);

    logic [RW-1:0]   c_rad  [0:SW];
    logic [SW+1:0]   c_rem  [0:SW];
    logic [SW-1:0]   c_root [0:SW];
    logic [SB-1:0]   c_side [0:SW];
    logic            c_val  [0:SW];

    // Radicand is the discriminant scaled by 2^(2*FB), zero-extended at the top to the even width RW.
    assign c_rad[0]  = {{(RW-DW-2*FB){1'b0}}, i_rad, {(2*FB){1'b0}}};
    assign c_rem[0]  = '0;
    assign c_root[0] = '0;
    assign c_side[0] = i_side;
    assign c_val[0]  = i_valid;

    for (genvar k = 0; k < SW; k++) begin : g_stage
        logic [RW-1:0] r_rad;
        logic [SW+1:0] r_rem;
        logic [SW-1:0] r_root;
        logic [SB-1:0] r_side;
        logic          r_val;
        logic [SW+1:0] n_shift, n_trial;

        always_comb begin
            n_shift = {c_rem[k][SW-1:0], c_rad[k][RW-1 -: 2]};
            n_trial = {c_root[k], 2'b01};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_val <= 1'b0;
            end else if (i_en) begin
                r_val <= c_val[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad  <= {c_rad[k][RW-3:0], 2'b00};
                r_side <= c_side[k];
                if (n_shift >= n_trial) begin
                    r_rem  <= n_shift - n_trial;
                    r_root <= {c_root[k][SW-2:0], 1'b1};
                end else begin
                    r_rem  <= n_shift;
                    r_root <= {c_root[k][SW-2:0], 1'b0};
                end
            end
        end

        assign c_rad[k+1]  = r_rad;
        assign c_rem[k+1]  = r_rem;
        assign c_root[k+1] = r_root;
        assign c_side[k+1] = r_side;
        assign c_val[k+1]  = r_val;
    end

    assign o_valid = c_val[SW];
    assign o_root  = c_root[SW];
    assign o_side  = c_side[SW];

endmodule

>>> rtl/core/qrs_div.sv
// ----------------------------------------------------------------------------
// qrs_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module qrs_div #(
    parameter int NW = 33,
    parameter int DNW = 17,
    parameter int SB = 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [NW-1:0]  i_num,
    input  logic [DNW-1:0] i_den,
    input  logic [SB-1:0]  i_side,
    output logic           o_valid,
    output logic [NW-1:0]  o_quot,
    output logic [SB-1:0]  o_side
);

    logic [NW-1:0]  c_num  [0:NW];
    logic [DNW:0]   c_rem  [0:NW];
    logic [DNW-1:0] c_den  [0:NW];
    logic [SB-1:0]  c_side [0:NW];
    logic           c_val  [0:NW];

    assign c_num[0]  = i_num;
    assign c_rem[0]  = '0;
    assign c_den[0]  = i_den;
    assign c_side[0] = i_side;
    assign c_val[0]  = i_valid;

    // The numerator register shifts out dividend bits and shifts in quotient bits.
    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic [NW-1:0]  r_num;
        logic [DNW:0]   r_rem;
        logic [DNW-1:0] r_den;
        logic [SB-1:0]  r_side;
        logic           r_val;
        logic [DNW:0]   n_shift;
        logic           n_ge;

        always_comb begin
            n_shift = {c_rem[k][DNW-1:0], c_num[k][NW-1]};
            n_ge    = (n_shift >= {1'b0, c_den[k]});
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_val <= 1'b0;
            end else if (i_en) begin
                r_val <= c_val[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den  <= c_den[k];
                r_side <= c_side[k];
                r_num  <= {c_num[k][NW-2:0], n_ge};
                r_rem  <= n_ge ? (n_shift - {1'b0, c_den[k]}) : n_shift;
            end
        end

        assign c_num[k+1]  = r_num;
        assign c_rem[k+1]  = r_rem;
        assign c_den[k+1]  = r_den;
        assign c_side[k+1] = r_side;
        assign c_val[k+1]  = r_val;
    end

    assign o_valid = c_val[NW];
    assign o_quot  = c_num[NW];
    assign o_side  = c_side[NW];

endmodule

>>> rtl/core/quadratic_root_solver_core.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver_core
// Real roots of a*x^2 + b*x + c in fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one coefficient set per transfer: tdata holds
//   coef_a, coef_b and coef_c from the lowest bit up. The master stream
//   returns one result per set, in order: tdata holds root_plus and
//   root_minus, tuser holds the status (real roots, no real roots, a is zero).
//   Roots carry FRAC_BITS fraction bits; divisions truncate toward zero.
//   The pipeline has three front-end stages, one per square root bit, one
//   numerator stage, one per quotient bit and the output register. The
//   square root and the two dividers are unrolled into stages, so one set
//   is accepted every cycle unless the receiver stalls. When the receiver
//   stalls with a result waiting, the whole pipeline holds and tready
//   drops; nothing is lost or repeated.
//   Reset clears all valid bits; no result is shown until new sets arrive.
// ----------------------------------------------------------------------------
module quadratic_root_solver_core import qrs_pkg::*; #(
    parameter int COEF_WIDTH = COEF_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    localparam int IN_W = ((3 * COEF_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((2 * ROOT_WIDTH + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [IN_W-1:0]  i_s_axis_tdata,   // coef_a, coef_b, coef_c
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [OUT_W-1:0] o_m_axis_tdata,   // root_plus, root_minus
    output logic [1:0]       o_m_axis_tuser    // status
);

    localparam int CW  = COEF_WIDTH;
    localparam int DW  = 2 * CW + 1;
    localparam int SW  = CW + 1 + FRAC_BITS;
    localparam int NUW = CW + FRAC_BITS + 2;
    localparam int MW  = NUW - 1;
    localparam int QW  = MW + 1;
    localparam int XW  = (QW > ROOT_WIDTH) ? QW : ROOT_WIDTH + 1;
    localparam int SQ_SB = 1 + 1 + CW + CW + 2;
    localparam int DV_SB = 1 + 2;

    localparam logic signed [XW-1:0] OUT_MAX =
        {{(XW-ROOT_WIDTH+1){1'b0}}, {(ROOT_WIDTH-1){1'b1}}};
    localparam logic signed [XW-1:0] OUT_MIN =
        {{(XW-ROOT_WIDTH+1){1'b1}}, {(ROOT_WIDTH-1){1'b0}}};

    logic w_en;

    logic          w_d_valid, w_d_b_neg, w_d_a_neg;
    logic [DW-1:0] w_d_disc;
    logic [CW-1:0] w_d_b_mag, w_d_a_mag;
    t_status       w_d_status;

    logic             w_s_valid;
    logic [SW-1:0]    w_s_root;
    logic [SQ_SB-1:0] w_s_side;
    logic             w_s_b_neg, w_s_a_neg;
    logic [CW-1:0]    w_s_b_mag, w_s_a_mag;
    logic [1:0]       w_s_status;

    logic                  r_n_valid, r_n_a_neg, r_n_p_neg, r_n_m_neg;
    logic [MW-1:0]         r_n_p_mag, r_n_m_mag;
    logic [CW:0]           r_n_den;
    logic [1:0]            r_n_status;
    logic [MW-1:0]         n_bsh, n_add, n_s_m_b, n_b_m_s, n_diff;
    logic                  n_s_ge;

    logic             w_p_valid, w_m_valid;
    logic [MW-1:0]    w_p_quot, w_m_quot;
    logic [DV_SB-1:0] w_p_side, w_m_side;

    logic                   r_out_valid;
    logic [ROOT_WIDTH-1:0]  r_out_plus, r_out_minus;
    logic [1:0]             r_out_status;
    logic [ROOT_WIDTH-1:0]  n_plus, n_minus;

    assign w_en = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    qrs_disc #(.CW(CW)) u_disc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_s_axis_tvalid),
        .i_a      (i_s_axis_tdata[CW-1:0]),
        .i_b      (i_s_axis_tdata[2*CW-1:CW]),
        .i_c      (i_s_axis_tdata[3*CW-1:2*CW]),
        .o_valid  (w_d_valid),
        .o_disc   (w_d_disc),
        .o_b_neg  (w_d_b_neg),
        .o_b_mag  (w_d_b_mag),
        .o_a_neg  (w_d_a_neg),
        .o_a_mag  (w_d_a_mag),
        .o_status (w_d_status)
    );

    qrs_sqrt #(.DW(DW), .FB(FRAC_BITS), .SB(SQ_SB)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_d_valid),
        .i_rad   (w_d_disc),
        .i_side  ({w_d_b_neg, w_d_a_neg, w_d_b_mag, w_d_a_mag, w_d_status}),
        .o_valid (w_s_valid),
        .o_root  (w_s_root),
        .o_side  (w_s_side)
    );

    assign {w_s_b_neg, w_s_a_neg, w_s_b_mag, w_s_a_mag, w_s_status} = w_s_side;

    // Numerators (-b << FRAC_BITS) +/- s, split into sign and magnitude.
    // The sum and both differences are formed side by side so that only one
    // adder delay lies on any path through this stage.
    always_comb begin
        n_bsh   = {1'b0, w_s_b_mag, {FRAC_BITS{1'b0}}};
        n_add   = n_bsh + w_s_root;
        n_s_m_b = w_s_root - n_bsh;
        n_b_m_s = n_bsh - w_s_root;
        n_s_ge  = (w_s_root >= n_bsh);
        n_diff  = n_s_ge ? n_s_m_b : n_b_m_s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_valid <= 1'b0;
        end else if (w_en) begin
            r_n_valid <= w_s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_n_p_neg  <= !w_s_b_neg && !n_s_ge;
            r_n_m_neg  <= !w_s_b_neg || n_s_ge;
            r_n_p_mag  <= w_s_b_neg ? n_add : n_diff;
            r_n_m_mag  <= w_s_b_neg ? n_diff : n_add;
            r_n_den    <= {w_s_a_mag, 1'b0};
            r_n_a_neg  <= w_s_a_neg;
            r_n_status <= w_s_status;
        end
    end

    qrs_div #(.NW(MW), .DNW(CW + 1), .SB(DV_SB)) u_div_plus (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_n_valid),
        .i_num   (r_n_p_mag),
        .i_den   (r_n_den),
        .i_side  ({r_n_p_neg ^ r_n_a_neg, r_n_status}),
        .o_valid (w_p_valid),
        .o_quot  (w_p_quot),
        .o_side  (w_p_side)
    );

    qrs_div #(.NW(MW), .DNW(CW + 1), .SB(DV_SB)) u_div_minus (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_n_valid),
        .i_num   (r_n_m_mag),
        .i_den   (r_n_den),
        .i_side  ({r_n_m_neg ^ r_n_a_neg, r_n_status}),
        .o_valid (w_m_valid),
        .o_quot  (w_m_quot),
        .o_side  (w_m_side)
    );

    function automatic logic [ROOT_WIDTH-1:0] finish_root(
        input logic          neg,
        input logic [MW-1:0] mag
    );
        logic signed [XW-1:0] q;
        logic [ROOT_WIDTH-1:0] res;
        q = $signed({{(XW-MW){1'b0}}, mag});
        if (neg) begin
            q = -q;
        end
        if (q > OUT_MAX) begin
            res = OUT_MAX[ROOT_WIDTH-1:0];
        end else if (q < OUT_MIN) begin
            res = OUT_MIN[ROOT_WIDTH-1:0];
        end else begin
            res = q[ROOT_WIDTH-1:0];
        end
        return res;
    endfunction

    always_comb begin
        if (w_p_side[1:0] == ST_REAL) begin
            n_plus  = finish_root(w_p_side[2], w_p_quot);
            n_minus = finish_root(w_m_side[2], w_m_quot);
        end else begin
            n_plus  = '0;
            n_minus = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_plus   <= n_plus;
            r_out_minus  <= n_minus;
            r_out_status <= w_p_side[1:0];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_W-2*ROOT_WIDTH){1'b0}}, r_out_minus, r_out_plus};
    assign o_m_axis_tuser  = r_out_status;

`ifndef SYNTHESIS
    a_no_roots_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser != ST_REAL) |-> (o_m_axis_tdata == '0))
        else $error("non-real status with nonzero roots");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(w_s_valid) && $stable(r_n_valid) && $stable(w_p_valid))
        else $error("pipeline moved during a stall");

    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_p_valid == w_m_valid)
        else $error("divider pipelines out of step");
`endif

endmodule

>>> tb/sv/qrs_root_checker.sv
// ----------------------------------------------------------------------------
// qrs_root_checker
// Watches both streams of the quadratic root solver, computes the roots of
// every accepted coefficient set on its own, and compares each result, field
// by field and in order, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module qrs_root_checker import qrs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [47:0] i_s_tdata,    // coef_a, coef_b, coef_c
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [71:0] i_m_tdata,    // root_plus, root_minus
    input  logic [1:0]  i_m_tuser,    // status
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [33:0] root_plus;
        logic [33:0] root_minus;
        t_status     status;
    } t_roots;

    t_roots roots_due[$];

    // Bit-by-bit floor square root of a value below 2^68.
    function automatic longint isqrt(logic [127:0] val);
        logic [127:0] root;
        logic [127:0] trial;
        root = '0;
        for (int k = 33; k >= 0; k--) begin
            trial = root | (128'd1 << k);
            if (trial * trial <= val)
                root = trial;
        end
        return longint'(root);
    endfunction

    function automatic logic [33:0] divide_root(longint num, longint den);
        longint q;
        q = num / den;
        if (q > 64'sd8589934591)
            q = 64'sd8589934591;
        if (q < -64'sd8589934592)
            q = -64'sd8589934592;
        return q[33:0];
    endfunction

    function automatic t_roots solve_roots(logic [47:0] coefs);
        longint a, b, c, disc, s, base;
        t_roots r;
        a = longint'($signed(coefs[15:0]));
        b = longint'($signed(coefs[31:16]));
        c = longint'($signed(coefs[47:32]));
        r = '{root_plus: '0, root_minus: '0, status: ST_REAL};
        disc = b * b - 4 * a * c;
        if (a == 0) begin
            r.status = ST_A_ZERO;
        end else if (disc < 0) begin
            r.status = ST_NO_REAL;
        end else begin
            s = isqrt(128'(disc) << 32);
            base = -(b * 65536);
            r.root_plus = divide_root(base + s, 2 * a);
            r.root_minus = divide_root(base - s, 2 * a);
        end
        return r;
    endfunction

    assign o_pending = roots_due.size();

    always @(posedge i_clk) begin
        t_roots want;
        t_roots got;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready)
                roots_due.push_back(solve_roots(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                got = '{root_plus: i_m_tdata[33:0], root_minus: i_m_tdata[67:34],
                        status: t_status'(i_m_tuser)};
                if (roots_due.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("Unexpected result transfer: %p", got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = roots_due.pop_front();
                    if (got != want) begin
                        if (o_fail_count < 10)
                            $display("Root mismatch: expected %p, got %p", want, got);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

>>> tb/sv/tb_quadratic_root_solver_core.sv
// ----------------------------------------------------------------------------
// tb_quadratic_root_solver_core
// Drives directed and random coefficient sets into the root solver with
// random gaps on both streams and one long receiver stall, and reports the
// verdict from the checker's failure count and pending count.
// ----------------------------------------------------------------------------
module tb_quadratic_root_solver_core;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic [1:0]  m_tuser;
    int          fail_count;
    int          pending;
    logic        steady = 1'b0;
    logic        hold_off = 1'b0;
    int          quiet_cycles = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    quadratic_root_solver_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata), .o_m_axis_tuser(m_tuser)
    );

    qrs_root_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .i_m_tuser(m_tuser), .o_fail_count(fail_count), .o_pending(pending)
    );

    // Receiver: random stalls, none during the steady stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= !hold_off && (steady || $urandom_range(99) >= 19);
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 3000) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_coefs(logic signed [15:0] a, logic signed [15:0] b,
                              logic signed [15:0] c);
        if (!steady && $urandom_range(99) < 19) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {c, b, a};
        do @(posedge i_clk); while (!s_tready);
    endtask

    function automatic logic [15:0] rand_coef();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(64)) - 32);
            2: return 16'($signed($urandom_range(2000)) - 1000);
            default: return $urandom_range(1) ? 16'sh7fff - 16'($urandom_range(3))
                                              : 16'sh8000 + 16'($urandom_range(3));
        endcase
    endfunction

    initial begin
        logic [15:0] a, b, c;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: a zero, negative discriminant, double root, extremes.
        send_coefs(0, 5, 7);
        send_coefs(0, 0, 0);
        send_coefs(0, -32768, 32767);
        send_coefs(1, 0, 1);
        send_coefs(1, 1, 1);
        send_coefs(1, 2, 1);
        send_coefs(-1, 2, -1);
        send_coefs(1, 0, -1);
        send_coefs(1, -3, 2);
        send_coefs(2, 3, -5);
        send_coefs(-32768, -32768, 32767);
        send_coefs(32767, -32768, -32768);
        send_coefs(-32768, 32767, -32768);
        send_coefs(1, -32768, -32768);
        send_coefs(1, 32767, 0);
        send_coefs(-1, -32768, 32767);
        send_coefs(32767, 32767, 32767);
        send_coefs(-32768, 0, 0);
        send_coefs(3, 0, 7);
        send_coefs(-7, 1, 0);

        // Long receiver stall while the sender keeps offering sets.
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            for (int n = 0; n < 120; n++)
                send_coefs(rand_coef(), rand_coef(), rand_coef());
        join

        for (int n = 0; n < 880; n++) begin
            steady <= (n >= 300 && n < 450);
            a = rand_coef();
            b = rand_coef();
            c = rand_coef();
            // Mostly opposite signs of a and c so real roots dominate.
            if ($urandom_range(99) < 60 && (a[15] == c[15]))
                c = -c;
            send_coefs(a, b, c);
        end
        s_tvalid <= 1'b0;
        steady <= 1'b0;

        while (pending != 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
